[hdl/ppt_pkg.sv]
`timescale 1ns / 1ps

package ppt_pkg;

  // Table geometry
  localparam int CAPACITY = 16;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Word field widths
  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int IDX_W  = 4;
  localparam int STAT_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT    = 3'd0,
    OP_REMOVE    = 3'd1,
    OP_REMOVE_AT = 3'd2,
    OP_REPLACE   = 3'd3,
    OP_READ      = 3'd4
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE    = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_NOMATCH = 2'd2
  } stat_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_COMMIT,
    S_PLAN,
    S_SHIFT,
    S_FILL,
    S_READ,
    S_FINISH
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic  load;
    logic  scan_init;
    logic  scan_step;
    logic  scan_commit;
    logic  plan;
    logic  shift_step;
    logic  fill_step;
    logic  fill_commit;
    logic  read_issue;
    logic  read_take;
    logic  set_status;
    stat_e status_code;
    logic  emit;
  } ppt_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            idx_ok;
    logic            scan_done;
    logic            match_zero;
    logic            plan_even;
    logic            shift_done;
    logic            fill_done;
    logic            out_free;
  } ppt_stat_t;

endpackage

[hdl/ppt_ram.sv]
`timescale 1ns / 1ps

module ppt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/ppt_dp.sv]
`timescale 1ns / 1ps

module ppt_dp import ppt_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ppt_cmd_t                 cmd_i,
  output ppt_stat_t                stat_o,
  input  logic [OP_W-1:0]          operation_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic signed [DATA_W-1:0] new_value_i,
  input  logic [IDX_W-1:0]         index_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [STAT_W-1:0]        status_o,
  output logic [CNT_W-1:0]         matched_o,
  output logic signed [DATA_W-1:0] read_data_o,
  output logic [CNT_W-1:0]         stored_o,
  output logic [CNT_W-1:0]         evens_held_o
);

  // Latched operation
  logic [OP_W-1:0]   op_q;
  logic [DATA_W-1:0] val_q;
  logic [DATA_W-1:0] nval_q;
  logic [IDX_W-1:0]  idx_q;

  // Table occupancy
  logic [CNT_W-1:0] total_q, total_d;
  logic [CNT_W-1:0] even_q, even_d;

  // Pass pointers and counters
  logic [CNT_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0] keven_q, keven_d;
  logic [CNT_W-1:0] match_q, match_d;
  logic [CNT_W-1:0] sptr_q, sptr_d;
  logic [CNT_W-1:0] fptr_q, fptr_d;
  logic [CNT_W-1:0] fcnt_q, fcnt_d;
  logic             land_q, land_d;
  logic [CNT_W-1:0] land_pos_q, land_pos_d;
  stat_e            res_status_q, res_status_d;
  logic [DATA_W-1:0] rd_q;

  // Result register
  logic              out_valid_q, out_valid_d;
  logic [STAT_W-1:0] out_status_q;
  logic [CNT_W-1:0]  out_matched_q;
  logic [DATA_W-1:0] out_data_q;
  logic [CNT_W-1:0]  out_stored_q;
  logic [CNT_W-1:0]  out_evens_q;

  // RAM ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic [DATA_W-1:0] plan_val;
  logic [CNT_W-1:0]  ins_cnt;
  logic              plan_even;
  logic              issue_scan;
  logic              issue_shift;
  logic              skip;
  logic              fill_go;
  logic [CNT_W-1:0]  shift_dst;

  ppt_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Insertion plan: value and copy count
  assign plan_val  = (op_q == OP_REPLACE) ? nval_q : val_q;
  assign ins_cnt   = (op_q == OP_REPLACE) ? match_q : CNT_W'(1);
  assign plan_even = ~plan_val[0];

  assign issue_scan  = rd_ptr_q < total_q;
  assign issue_shift = sptr_q > even_q;
  assign fill_go     = fcnt_q < ins_cnt;
  assign shift_dst   = land_pos_q + ins_cnt;

  // Drop a landed word when it matches the value or the target position
  assign skip = (op_q == OP_REMOVE_AT) ? (land_pos_q == CNT_W'(idx_q))
                                       : (ram_rdata == val_q);

  // Steer the RAM read address
  always_comb begin
    if (cmd_i.read_issue) begin
      ram_raddr = ADDR_W'(idx_q);
    end else if (cmd_i.shift_step) begin
      ram_raddr = ADDR_W'(sptr_q - CNT_W'(1));
    end else begin
      ram_raddr = rd_ptr_q[ADDR_W-1:0];
    end
  end

  // Steer the RAM write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    if (cmd_i.scan_step && land_q && !skip) begin
      ram_we    = 1'b1;
      ram_waddr = wr_ptr_q[ADDR_W-1:0];
      ram_wdata = ram_rdata;
    end else if (cmd_i.shift_step && land_q) begin
      ram_we    = 1'b1;
      ram_waddr = shift_dst[ADDR_W-1:0];
      ram_wdata = ram_rdata;
    end else if (cmd_i.fill_step && fill_go) begin
      ram_we    = 1'b1;
      ram_waddr = fptr_q[ADDR_W-1:0];
      ram_wdata = plan_val;
    end
  end

  // Next state of counters and pointers
  always_comb begin
    total_d      = total_q;
    even_d       = even_q;
    rd_ptr_d     = rd_ptr_q;
    wr_ptr_d     = wr_ptr_q;
    keven_d      = keven_q;
    match_d      = match_q;
    sptr_d       = sptr_q;
    fptr_d       = fptr_q;
    fcnt_d       = fcnt_q;
    land_d       = 1'b0;
    land_pos_d   = land_pos_q;
    res_status_d = res_status_q;

    if (cmd_i.load) begin
      match_d      = '0;
      res_status_d = STAT_DONE;
    end

    if (cmd_i.scan_init) begin
      rd_ptr_d = '0;
      wr_ptr_d = '0;
      keven_d  = '0;
      match_d  = '0;
    end

    // Forward compaction pass
    if (cmd_i.scan_step) begin
      land_d     = issue_scan;
      land_pos_d = rd_ptr_q;
      if (issue_scan) begin
        rd_ptr_d = rd_ptr_q + CNT_W'(1);
      end
      if (land_q) begin
        if (skip) begin
          match_d = match_q + CNT_W'(1);
        end else begin
          wr_ptr_d = wr_ptr_q + CNT_W'(1);
          if (!ram_rdata[0]) begin
            keven_d = keven_q + CNT_W'(1);
          end
        end
      end
    end

    if (cmd_i.scan_commit) begin
      total_d = wr_ptr_q;
      even_d  = keven_q;
    end

    if (cmd_i.plan) begin
      sptr_d = total_q;
      fptr_d = plan_even ? even_q : total_q;
      fcnt_d = '0;
    end

    // Backward pass: move odd words up to open the even gap
    if (cmd_i.shift_step) begin
      land_d     = issue_shift;
      land_pos_d = sptr_q - CNT_W'(1);
      if (issue_shift) begin
        sptr_d = sptr_q - CNT_W'(1);
      end
    end

    if (cmd_i.fill_step && fill_go) begin
      fptr_d = fptr_q + CNT_W'(1);
      fcnt_d = fcnt_q + CNT_W'(1);
    end

    if (cmd_i.fill_commit) begin
      total_d = total_q + ins_cnt;
      if (plan_even) begin
        even_d = even_q + ins_cnt;
      end
    end

    if (cmd_i.set_status) begin
      res_status_d = cmd_i.status_code;
    end
  end

  // Result valid: set on emit, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q      <= '0;
      even_q       <= '0;
      rd_ptr_q     <= '0;
      wr_ptr_q     <= '0;
      keven_q      <= '0;
      match_q      <= '0;
      sptr_q       <= '0;
      fptr_q       <= '0;
      fcnt_q       <= '0;
      land_q       <= 1'b0;
      land_pos_q   <= '0;
      res_status_q <= STAT_DONE;
      out_valid_q  <= 1'b0;
    end else begin
      total_q      <= total_d;
      even_q       <= even_d;
      rd_ptr_q     <= rd_ptr_d;
      wr_ptr_q     <= wr_ptr_d;
      keven_q      <= keven_d;
      match_q      <= match_d;
      sptr_q       <= sptr_d;
      fptr_q       <= fptr_d;
      fcnt_q       <= fcnt_d;
      land_q       <= land_d;
      land_pos_q   <= land_pos_d;
      res_status_q <= res_status_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Capture the input word, read data and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= operation_i;
      val_q  <= value_i;
      nval_q <= new_value_i;
      idx_q  <= index_i;
      rd_q   <= '0;
    end else if (cmd_i.read_take) begin
      rd_q <= ram_rdata;
    end
    if (cmd_i.emit) begin
      out_status_q  <= res_status_q;
      out_matched_q <= match_q;
      out_data_q    <= rd_q;
      out_stored_q  <= total_q;
      out_evens_q   <= even_q;
    end
  end

  // Status to the controller
  always_comb begin
    stat_o            = '0;
    stat_o.op         = op_q;
    stat_o.full       = total_q >= CNT_W'(CAPACITY);
    stat_o.idx_ok     = CNT_W'(idx_q) < total_q;
    stat_o.scan_done  = !issue_scan && !land_q;
    stat_o.match_zero = match_q == '0;
    stat_o.plan_even  = plan_even;
    stat_o.shift_done = !issue_shift && !land_q;
    stat_o.fill_done  = !fill_go;
    stat_o.out_free   = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign matched_o    = out_matched_q;
  assign read_data_o  = out_data_q;
  assign stored_o     = out_stored_q;
  assign evens_held_o = out_evens_q;

endmodule

[hdl/ppt_ctrl.sv]
`timescale 1ns / 1ps

module ppt_ctrl import ppt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ppt_stat_t stat_i,
  output ppt_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      // Take a new word
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECIDE;
        end
      end

      // Dispatch on the operation
      S_DECIDE: begin
        case (stat_i.op)
          OP_INSERT: begin
            if (stat_i.full) begin
              cmd_o.set_status  = 1'b1;
              cmd_o.status_code = STAT_FULL;
              state_d           = S_FINISH;
            end else begin
              state_d = S_PLAN;
            end
          end
          OP_REMOVE, OP_REPLACE: begin
            cmd_o.scan_init = 1'b1;
            state_d         = S_SCAN;
          end
          OP_REMOVE_AT: begin
            if (stat_i.idx_ok) begin
              cmd_o.scan_init = 1'b1;
              state_d         = S_SCAN;
            end else begin
              cmd_o.set_status  = 1'b1;
              cmd_o.status_code = STAT_NOMATCH;
              state_d           = S_FINISH;
            end
          end
          OP_READ: begin
            if (stat_i.idx_ok) begin
              cmd_o.read_issue = 1'b1;
              state_d          = S_READ;
            end else begin
              cmd_o.set_status  = 1'b1;
              cmd_o.status_code = STAT_NOMATCH;
              state_d           = S_FINISH;
            end
          end
          default: begin
            state_d = S_FINISH;
          end
        endcase
      end

      // Compact the table, dropping matches
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_done) begin
          state_d = S_COMMIT;
        end
      end

      S_COMMIT: begin
        cmd_o.scan_commit = 1'b1;
        if (stat_i.match_zero) begin
          cmd_o.set_status  = 1'b1;
          cmd_o.status_code = STAT_NOMATCH;
          state_d           = S_FINISH;
        end else if (stat_i.op == OP_REPLACE) begin
          state_d = S_PLAN;
        end else begin
          state_d = S_FINISH;
        end
      end

      S_PLAN: begin
        cmd_o.plan = 1'b1;
        state_d    = stat_i.plan_even ? S_SHIFT : S_FILL;
      end

      // Open room after the even group
      S_SHIFT: begin
        cmd_o.shift_step = 1'b1;
        if (stat_i.shift_done) begin
          state_d = S_FILL;
        end
      end

      // Write the new copies
      S_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (stat_i.fill_done) begin
          cmd_o.fill_commit = 1'b1;
          state_d           = S_FINISH;
        end
      end

      S_READ: begin
        cmd_o.read_take = 1'b1;
        state_d         = S_FINISH;
      end

      // Hold until the result register is free
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

[hdl/parity_partitioned_table.sv]
`timescale 1ns / 1ps

// Table of up to 16 signed words, even values ahead of odd values, each
// group in arrival order. One input word carries an operation (insert,
// remove all of a value, remove at index, replace, read); each produces one
// result word with status, match count, read data and the occupancy after it.
// Input channel: in_valid_i / in_stall_o; a word is taken when valid is high
// and stall low. in_stall_o is low only while no operation is in progress.
// Output channel: out_valid_o / out_stall_i with a result register, so a new
// input word is taken while the previous result still waits.
// Each word is first decoded. Remove, remove at index and replace compact
// the table in a forward pass that drops the matching entries; a replace
// with matches or an insert then writes the new copies, after a backward
// pass that moves odd entries up when the new value is even. A read takes
// its data from the RAM; a refused operation or spare code goes straight to
// the result; then the controller goes idle to take the next word. Each
// pass moves one entry per cycle through the one-read, one-write table RAM.
// Reset empties the table by clearing the counts and drops any pending
// result; the table memory is not cleared. While out_stall_i is high a
// pending result holds and a finished operation waits for the result register.

module parity_partitioned_table import ppt_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [OP_W-1:0]          operation_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic signed [DATA_W-1:0] new_value_i,
  input  logic [IDX_W-1:0]         index_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [STAT_W-1:0]        status_o,
  output logic [CNT_W-1:0]         matched_o,
  output logic signed [DATA_W-1:0] read_data_o,
  output logic [CNT_W-1:0]         stored_o,
  output logic [CNT_W-1:0]         evens_held_o
);

  ppt_cmd_t  cmd;
  ppt_stat_t stat;

  ppt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ppt_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .operation_i  (operation_i),
    .value_i      (value_i),
    .new_value_i  (new_value_i),
    .index_i      (index_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .matched_o    (matched_o),
    .read_data_o  (read_data_o),
    .stored_o     (stored_o),
    .evens_held_o (evens_held_o)
  );

endmodule

[hdl/ppt_checker.sv]
`timescale 1ns / 1ps

module ppt_checker import ppt_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_i,
  input logic                     out_stall_i,
  input logic [STAT_W-1:0]        status_i,
  input logic [CNT_W-1:0]         matched_i,
  input logic signed [DATA_W-1:0] read_data_i,
  input logic [CNT_W-1:0]         stored_i,
  input logic [CNT_W-1:0]         evens_held_i
);

  // Stalled result stays presented
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // Stalled result occupancy and read data do not change
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=>
      $stable(stored_i) && $stable(evens_held_i) && $stable(read_data_i))
    else $error("result changed while stalled");

  // Occupancy stays within the table and evens within occupancy
  a_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> stored_i <= CNT_W'(CAPACITY) && evens_held_i <= stored_i)
    else $error("occupancy out of range");

  // A refused insert only happens on a full table
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == STAT_FULL |->
      stored_i == CNT_W'(CAPACITY) && matched_i == '0)
    else $error("full status on a table that is not full");

  // Read data only comes with a clean read
  a_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && read_data_i != '0 |-> status_i == STAT_DONE && matched_i == '0)
    else $error("read data on a result that is not a read");

endmodule

bind parity_partitioned_table ppt_checker u_ppt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_i     (status_o),
  .matched_i    (matched_o),
  .read_data_i  (read_data_o),
  .stored_i     (stored_o),
  .evens_held_i (evens_held_o)
);

[bench/parity_partitioned_table_tb.sv]
`timescale 1ns / 1ps

module parity_partitioned_table_tb import ppt_pkg::*; ();

  // Operation codes the block treats as no-ops
  localparam logic [OP_W-1:0]   OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0]   OP_SPARE_HI = 3'd7;
  localparam logic [DATA_W-1:0] VAL_MIN     = 32'h8000_0000;
  localparam logic [DATA_W-1:0] VAL_MAX     = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] VAL_NEG_ONE = 32'hFFFF_FFFF;
  localparam int RANDOM_ITEMS = 1870;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  matched;
    logic [DATA_W-1:0] read_data;
    logic [CNT_W-1:0]  stored;
    logic [CNT_W-1:0]  evens_held;
  } table_result_t;

  class table_scoreboard;
    bit [DATA_W-1:0] slots[CAPACITY];
    int              even_cnt;
    int              odd_cnt;
    int              total_cnt;
    table_result_t   awaited[$];
    int              errors;

    function int count();
      return total_cnt;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function logic [DATA_W-1:0] any_entry();
      return slots[$urandom_range(0, total_cnt - 1)];
    endfunction

    // Evens go to the end of the even group, odds to the end of the table
    function bit put_word(bit [DATA_W-1:0] v);
      int i;
      if (total_cnt >= CAPACITY) return 1'b0;
      if (!v[0]) begin
        for (i = total_cnt; i > even_cnt; i--) slots[i] = slots[i-1];
        slots[even_cnt] = v;
        even_cnt++;
      end else begin
        slots[total_cnt] = v;
        odd_cnt++;
      end
      total_cnt++;
      return 1'b1;
    endfunction

    function void drop_slot(int pos);
      int i;
      if (!slots[pos][0]) even_cnt--;
      else odd_cnt--;
      for (i = pos + 1; i < total_cnt; i++) slots[i-1] = slots[i];
      total_cnt--;
    endfunction

    function int drop_value(bit [DATA_W-1:0] v);
      int p;
      int n;
      p = 0;
      n = 0;
      while (p < total_cnt) begin
        if (slots[p] == v) begin
          drop_slot(p);
          n++;
        end else begin
          p++;
        end
      end
      return n;
    endfunction

    // Apply one accepted word to the table image and queue its result
    function void take_command(logic [OP_W-1:0] op, logic [DATA_W-1:0] v,
                               logic [DATA_W-1:0] nv, logic [IDX_W-1:0] idx);
      table_result_t r;
      int k;
      int hits;
      r.status    = STAT_DONE;
      r.read_data = '0;
      hits        = 0;
      case (op)
        OP_INSERT: begin
          if (!put_word(v)) r.status = STAT_FULL;
        end
        OP_REMOVE: begin
          hits = drop_value(v);
          if (hits == 0) r.status = STAT_NOMATCH;
        end
        OP_REMOVE_AT: begin
          if (int'(idx) < total_cnt) begin
            drop_slot(int'(idx));
            hits = 1;
          end else begin
            r.status = STAT_NOMATCH;
          end
        end
        OP_REPLACE: begin
          hits = drop_value(v);
          if (hits == 0) r.status = STAT_NOMATCH;
          for (k = 0; k < hits; k++) void'(put_word(nv));
        end
        OP_READ: begin
          if (int'(idx) < total_cnt) r.read_data = slots[idx];
          else r.status = STAT_NOMATCH;
        end
        default: ;
      endcase
      r.matched    = CNT_W'(hits);
      r.stored     = CNT_W'(total_cnt);
      r.evens_held = CNT_W'(even_cnt);
      awaited.push_back(r);
    endfunction

    function void compare_field(string name, logic [DATA_W-1:0] want,
                                logic [DATA_W-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(table_result_t got);
      table_result_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result word: status %0d stored %0d", got.status, got.stored);
        errors++;
        return;
      end
      want = awaited.pop_front();
      compare_field("status", DATA_W'(want.status), DATA_W'(got.status));
      compare_field("matched", DATA_W'(want.matched), DATA_W'(got.matched));
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("stored", DATA_W'(want.stored), DATA_W'(got.stored));
      compare_field("evens_held", DATA_W'(want.evens_held), DATA_W'(got.evens_held));
    endfunction
  endclass

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid    = 1'b0;
  logic                     in_stall_o;
  logic [OP_W-1:0]          operation   = OP_INSERT;
  logic signed [DATA_W-1:0] value       = '0;
  logic signed [DATA_W-1:0] new_value   = '0;
  logic [IDX_W-1:0]         index       = '0;
  logic                     out_valid_o;
  logic                     out_stall   = 1'b0;
  logic [STAT_W-1:0]        status_o;
  logic [CNT_W-1:0]         matched_o;
  logic signed [DATA_W-1:0] read_data_o;
  logic [CNT_W-1:0]         stored_o;
  logic [CNT_W-1:0]         evens_held_o;

  table_scoreboard sb;
  bit in_idle_on  = 1'b0;
  bit out_idle_on = 1'b0;
  int stall_left  = 0;
  int quiet_cycles = 0;

  parity_partitioned_table uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .operation_i (operation),
    .value_i     (value),
    .new_value_i (new_value),
    .index_i     (index),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .status_o    (status_o),
    .matched_o   (matched_o),
    .read_data_o (read_data_o),
    .stored_o    (stored_o),
    .evens_held_o(evens_held_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Check result words, stall the output in bursts, watch for a hang
  always @(posedge clk_i) begin
    table_result_t got;
    if (rst_ni && out_valid_o && !out_stall) begin
      got.status     = status_o;
      got.matched    = matched_o;
      got.read_data  = read_data_o;
      got.stored     = stored_o;
      got.evens_held = evens_held_o;
      sb.check_result(got);
    end
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
    if (stall_left == 0 && out_idle_on && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 12);
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Present one word and hold it until the block takes it
  task automatic send_word(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] v,
                           input logic [DATA_W-1:0] nv, input logic [IDX_W-1:0] idx);
    if (in_idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    operation <= op;
    value     <= v;
    new_value <= nv;
    index     <= idx;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_command(op, v, nv, idx);
  endtask

  // Hold off the sender until every result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() > 0);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    int sel;
    int s;
    sel = $urandom_range(0, 9);
    s   = $urandom_range(0, 8);
    if (sel < 6) return s - 4;
    if (sel == 6) return s[0] ? VAL_MIN : VAL_MAX;
    return $urandom;
  endfunction

  // Mostly valid operations on values already held, sized to keep the table busy
  task automatic send_random();
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] v;
    logic [DATA_W-1:0] nv;
    logic [IDX_W-1:0]  idx;
    int n;
    int ins_weight;
    int r;
    n = sb.count();
    ins_weight = (n == CAPACITY) ? 12 : ((n < 6) ? 55 : 35);
    r = $urandom_range(0, 99);
    if (r < ins_weight) begin
      op = OP_INSERT;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 18) op = OP_REMOVE;
      else if (r < 40) op = OP_REMOVE_AT;
      else if (r < 60) op = OP_REPLACE;
      else if (r < 97) op = OP_READ;
      else op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    end
    v  = pick_value();
    nv = pick_value();
    if ((op == OP_REMOVE || op == OP_REPLACE) && n > 0 && $urandom_range(0, 4) != 0)
      v = sb.any_entry();
    if (n > 0 && $urandom_range(0, 3) != 0) idx = IDX_W'($urandom_range(0, n - 1));
    else idx = IDX_W'($urandom_range(0, CAPACITY - 1));
    send_word(op, v, nv, idx);
  endtask

  initial begin
    int k;
    int mode;
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table: read past the end, remove and remove at index with nothing held
    send_word(OP_READ, '0, '0, IDX_W'(CAPACITY - 1));
    send_word(OP_REMOVE, '0, '0, '0);
    send_word(OP_REMOVE_AT, VAL_MAX, '0, '0);
    // Extremes of both parities
    send_word(OP_INSERT, VAL_MIN, '0, '0);
    send_word(OP_INSERT, VAL_MAX, '0, '0);
    send_word(OP_INSERT, VAL_NEG_ONE, '0, '0);
    send_word(OP_INSERT, '0, '0, '0);
    send_word(OP_READ, '0, '0, IDX_W'(1));
    // Odd value replaced by an even one, then remove an even and an odd slot
    send_word(OP_REPLACE, VAL_NEG_ONE, 2, '0);
    send_word(OP_REMOVE_AT, '0, '0, '0);
    send_word(OP_REMOVE_AT, '0, '0, IDX_W'(2));
    send_word(OP_REPLACE, 7, 1, '0);
    send_word(OP_SPARE_LO, VAL_NEG_ONE, VAL_NEG_ONE, IDX_W'(CAPACITY - 1));
    send_word(OP_SPARE_HI, VAL_MIN, VAL_MAX, '0);
    // Fill to capacity, then refuse one more
    while (sb.count() < CAPACITY) send_word(OP_INSERT, 4, '0, '0);
    send_word(OP_INSERT, 3, '0, '0);
    send_word(OP_READ, '0, '0, IDX_W'(CAPACITY - 1));
    send_word(OP_REPLACE, 4, 9, '0);
    send_word(OP_REMOVE, 9, '0, '0);
    drain_results();

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 150 == 0) begin
        mode = $urandom_range(0, 3);
        in_idle_on  = mode[0];
        out_idle_on = mode[1];
      end
      if (k >= RANDOM_ITEMS - 300) begin
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
      end
      if (k % 450 == 225) drain_results();
      send_random();
    end

    // Let the last results land and catch any stray extras
    in_valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
hdl/ppt_pkg.sv
hdl/ppt_ram.sv
hdl/ppt_dp.sv
hdl/ppt_ctrl.sv
hdl/parity_partitioned_table.sv
hdl/ppt_checker.sv
bench/parity_partitioned_table_tb.sv
